### sv/amas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_pkg
// Shared constants and widths for the moving-average voltage scaler.
// ----------------------------------------------------------------------------
package amas_pkg;

    localparam int DEPTH       = 32;
    localparam int SAMPLE_BITS = 10;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SUM_W       = SAMPLE_BITS + PTR_W;
    localparam int GAIN_W      = 24;
    localparam int VOLT_W      = 16;
    localparam int PROD_W      = SAMPLE_BITS + GAIN_W;
    localparam int GAIN_SHIFT  = 16;

    localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

endpackage : amas_pkg
`default_nettype wire

### sv/amas_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module amas_div
    import amas_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [SUM_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W:0]    diff;

    assign trial = {rem_reg, quot_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], fits};
            rem_reg  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule : amas_div
`default_nettype wire

### sv/adc_moving_average_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_moving_average_scaler
// Ring of recent samples in a synchronous RAM; the newest n samples are
// summed by walking the RAM, divided serially, then scaled by a Q16 gain.
// ----------------------------------------------------------------------------
// Steps: a walk of the RAM for the n samples averaged (1..32), one read per
//   cycle, then the serial divider, the multiply and the load of the result.
// Flow: one beat at a time; the next input beat is taken once the result is
//   loaded into the output register.
// Reset: async active low; pointer and count clear, window = 32, gain = 65536.
// ----------------------------------------------------------------------------
module adc_moving_average_scaler
    import amas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [9:0] average_raw, [25:10] voltage_q8,
                                        // [31:26] samples_used
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]             state_reg;
    logic [CNT_W-1:0]       window_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [PTR_W-1:0]       wp_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       issue_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic                   pend_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   out_valid_reg;
    logic [31:0]            out_data_reg;

    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic                   cfg_wr;
    logic [CNT_W-1:0]       win_wr;
    logic [CNT_W-1:0]       win_next;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       n_next;
    logic                   rd_en;
    logic [PTR_W-1:0]       rd_addr;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quot;
    logic                   out_free;
    logic [VOLT_W-1:0]      volts;

    // configuration
    assign cfg_wr = psel & penable & pwrite & pready;
    assign win_wr = pwdata[CNT_W-1:0];
    always_comb
    begin
        if (win_wr == '0)
            win_next = CNT_W'(1);
        else if (win_wr > DEPTH_CNT)
            win_next = DEPTH_CNT;
        else
            win_next = win_wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= DEPTH_CNT;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                gain_reg <= pwdata[GAIN_W-1:0];
            else
                window_reg <= win_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'(gain_reg) : 32'(window_reg);

    // input side
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign sample     = s_tdata[SAMPLE_BITS-1:0];
    assign count_next = (count_reg == DEPTH_CNT) ? DEPTH_CNT : count_reg + 1'b1;
    assign n_next     = (count_next < window_reg) ? count_next : window_reg;

    assign rd_en     = (state_reg == ST_SUM) && (issue_reg != '0);
    assign rd_addr   = (rd_ptr_reg == '0) ? LAST_PTR : rd_ptr_reg - 1'b1;
    assign div_start = (state_reg == ST_SUM) && (issue_reg == '0) && !pend_reg;
    assign out_free  = !out_valid_reg || m_tready;

    // sample ring
    always_ff @(posedge clk)
    begin
        if (accept)
            mem[wp_reg] <= sample;
        rd_data_reg <= mem[rd_addr];
    end

    amas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign volts = (prod_reg[PROD_W-1:GAIN_SHIFT+VOLT_W] != '0) ? '1
                 : prod_reg[GAIN_SHIFT+VOLT_W-1:GAIN_SHIFT];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        wp_reg    <= (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;
                        count_reg <= count_next;
                        issue_reg <= n_next - 1'b1;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    pend_reg <= rd_en;
                    if (rd_en)
                        issue_reg <= issue_reg - 1'b1;
                    if (div_start)
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg    <= SUM_W'(sample);
            n_reg      <= n_next;
            rd_ptr_reg <= wp_reg;
        end
        else if (state_reg == ST_SUM)
        begin
            if (rd_en)
                rd_ptr_reg <= rd_addr;
            if (pend_reg)
                sum_reg <= sum_reg + SUM_W'(rd_data_reg);
        end
        if (state_reg == ST_DIV && div_done)
            mean_reg <= div_quot[SAMPLE_BITS-1:0];
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'(mean_reg) * PROD_W'(gain_reg);
        if (state_reg == ST_OUT && out_free)
            out_data_reg <= {n_reg, volts, mean_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule : adc_moving_average_scaler
`default_nettype wire
